FILE: src/mch_pkg.sv
// ----------------------------------------------------------------------------
// mch_pkg
// Shared constants, angle table and controller/datapath interface types.
// ----------------------------------------------------------------------------
package mch_pkg;

    localparam int SCALE_FRAC_BITS = 14;
    localparam int CORDIC_STEPS    = 16;

    localparam int RAW_W    = 16;
    localparam int FIELD_W  = 20;
    localparam int HEAD_W   = 16;
    localparam int COUNT_W  = 12;
    localparam int SCALE_W  = 16;
    localparam int HALF_W   = 15;
    localparam int ROT_W    = 32;
    localparam int ANG_W    = 26;
    localparam int CNT_W    = 5;
    localparam int STEP_W   = (CORDIC_STEPS > 16) ? 5 : 4;
    localparam int QUO_W    = 16;
    localparam int NUM_W    = HALF_W + SCALE_FRAC_BITS;
    localparam int IN_W     = 3 * RAW_W;
    localparam int OUT_W    = ((3 * FIELD_W + HEAD_W + 7) / 8) * 8;

    localparam int signed DEG180_Q16 = 11796480;
    localparam int signed DEG360_Q16 = 23592960;
    localparam int        HEADING_FULL = 46080;
    localparam int        CNT_RESET    = 500;
    // floor(x/3) = (x * 43691) >> 17 for x below 2^17
    localparam int        RECIP3       = 43691;
    localparam int        RECIP3_SH    = 17;

    typedef enum logic [1:0] {
        REG_RANGE  = 2'd0,
        REG_MODE   = 2'd1,
        REG_COUNT  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic              load_in;
        logic              mul_en;
        logic [1:0]        mul_axis;
        logic              sat_en;
        logic [1:0]        sat_axis;
        logic              rot_init;
        logic              rot_step;
        logic [STEP_W-1:0] step;
        logic              track;
        logic              half_calc;
        logic              avg_take;
        logic              div_init;
        logic              div_step;
        logic              div_store;
        logic [1:0]        div_axis;
        logic              out_load;
    } mch_cmd_t;

    typedef struct packed {
        logic in_good;
        logic calib_due;
        logic out_free;
    } mch_sts_t;

    // atan(2^-i) in degrees, 16 fraction bits
    function automatic logic [21:0] atan_deg(input logic [STEP_W-1:0] i);
        logic [21:0] v;
        begin
            unique case (5'(i))
                5'd0:    v = 22'd2949120;
                5'd1:    v = 22'd1740967;
                5'd2:    v = 22'd919879;
                5'd3:    v = 22'd466945;
                5'd4:    v = 22'd234379;
                5'd5:    v = 22'd117304;
                5'd6:    v = 22'd58666;
                5'd7:    v = 22'd29335;
                5'd8:    v = 22'd14668;
                5'd9:    v = 22'd7334;
                5'd10:   v = 22'd3667;
                5'd11:   v = 22'd1833;
                5'd12:   v = 22'd917;
                5'd13:   v = 22'd458;
                5'd14:   v = 22'd229;
                5'd15:   v = 22'd115;
                5'd16:   v = 22'd57;
                5'd17:   v = 22'd29;
                5'd18:   v = 22'd14;
                5'd19:   v = 22'd7;
                5'd20:   v = 22'd4;
                5'd21:   v = 22'd2;
                5'd22:   v = 22'd1;
                default: v = 22'd0;
            endcase
            return v;
        end
    endfunction

endpackage

FILE: src/mch_ctrl.sv
// ----------------------------------------------------------------------------
// mch_ctrl
// Sequencer: correction, CORDIC rotation, calibration load and output hand-off.
// ----------------------------------------------------------------------------
module mch_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  mch_pkg::mch_sts_t sts,
    output mch_pkg::mch_cmd_t cmd
);
    import mch_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CORR  = 8'b0000_0010,
        S_ROT   = 8'b0000_0100,
        S_TRACK = 8'b0000_1000,
        S_HALF  = 8'b0001_0000,
        S_AVG   = 8'b0010_0000,
        S_DIV   = 8'b0100_0000,
        S_FIN   = 8'b1000_0000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       axis_reg, axis_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        axis_next  = axis_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        cmd.mul_axis = cnt_reg[1:0];
        cmd.sat_axis = cnt_reg[1:0] - 2'd1;
        cmd.step     = cnt_reg[STEP_W-1:0];
        cmd.div_axis = axis_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    cnt_next    = '0;
                    state_next  = sts.in_good ? S_CORR : S_FIN;
                end
            end
            S_CORR:
            begin
                // multiply axis n while saturating axis n-1
                cmd.mul_en = (cnt_reg != CNT_W'(3));
                cmd.sat_en = (cnt_reg != '0);
                if (cnt_reg == CNT_W'(3))
                begin
                    cmd.rot_init = 1'b1;
                    cnt_next     = '0;
                    state_next   = S_ROT;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_ROT:
            begin
                cmd.rot_step = 1'b1;
                if (cnt_reg == CNT_W'(CORDIC_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_TRACK;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_TRACK:
            begin
                cmd.track  = 1'b1;
                state_next = sts.calib_due ? S_HALF : S_FIN;
            end
            S_HALF:
            begin
                cmd.half_calc = 1'b1;
                state_next    = S_AVG;
            end
            S_AVG:
            begin
                cmd.avg_take = 1'b1;
                cnt_next     = '0;
                axis_next    = 2'd0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_init  = (cnt_reg == '0);
                cmd.div_step  = (cnt_reg != '0);
                cmd.div_store = (cnt_reg == CNT_W'(QUO_W));
                if (cnt_reg == CNT_W'(QUO_W))
                begin
                    cnt_next = '0;
                    if (axis_reg == 2'd2)
                        state_next = S_FIN;
                    else
                        axis_next = axis_reg + 2'd1;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            axis_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            axis_reg  <= axis_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_good_starts_corr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && s_tvalid && sts.in_good) |=> (state_reg == S_CORR))
        else $error("good word did not start correction");
    a_bad_skips: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && s_tvalid && !sts.in_good) |=> (state_reg == S_FIN))
        else $error("bad word entered datapath");
    a_rot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROT) |-> (cnt_reg < CNT_W'(CORDIC_STEPS)))
        else $error("rotation count overrun");
    a_div_axis: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (axis_reg != 2'd3 && cnt_reg <= CNT_W'(QUO_W)))
        else $error("divider sequencing out of range");
`endif

endmodule

FILE: src/mch_datapath.sv
// ----------------------------------------------------------------------------
// mch_datapath
// Offset/scale correction, CORDIC heading, min/max tracking, scale divider.
// ----------------------------------------------------------------------------
module mch_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [mch_pkg::IN_W-1:0]      s_tdata,
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mch_pkg::OUT_W-1:0]     m_tdata,
    output logic [1:0]                    m_tuser,
    input  logic                          cfg_valid,
    input  logic [1:0]                    cfg_index,
    input  logic [mch_pkg::COUNT_W-1:0]   cfg_data,
    input  mch_pkg::mch_cmd_t             cmd,
    output mch_pkg::mch_sts_t             sts
);
    import mch_pkg::*;

    // configuration
    logic               range_reg;
    logic               mode_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] seen_reg;

    logic signed [RAW_W-1:0]   raw_reg    [3];
    logic signed [RAW_W-1:0]   offset_reg [3];
    logic        [SCALE_W-1:0] scale_reg  [3];
    logic signed [RAW_W-1:0]   min_reg    [3];
    logic signed [RAW_W-1:0]   max_reg    [3];
    logic        [HALF_W-1:0]  half_reg   [3];
    logic signed [FIELD_W-1:0] field_reg  [3];
    logic                      good_reg;
    logic                      done_reg;

    logic signed [2*RAW_W+1:0] prod_reg;
    logic signed [ROT_W-1:0]   x_reg, y_reg;
    logic signed [ANG_W-1:0]   z_reg;

    logic [RAW_W:0]            hsum_reg;
    logic [HALF_W-1:0]         avg_reg;
    logic [QUO_W-1:0]          rem_reg;
    logic [QUO_W-1:0]          num_reg;
    logic [QUO_W-1:0]          quo_reg;
    logic                      dsat_reg;

    logic                      m_tvalid_reg;
    logic [OUT_W-1:0]          m_tdata_reg;
    logic [1:0]                m_tuser_reg;

    // correction
    logic signed [RAW_W:0]     diff;
    logic signed [2*RAW_W+1:0] prod;
    logic signed [2*RAW_W+2:0] rnd;
    logic signed [2*RAW_W+2:0] shr;
    logic signed [FIELD_W-1:0] sat_val;

    always_comb
    begin
        diff = (RAW_W+1)'(raw_reg[cmd.mul_axis]) - (RAW_W+1)'(offset_reg[cmd.mul_axis]);
        prod = (2*RAW_W+2)'(diff * $signed({1'b0, scale_reg[cmd.mul_axis]}));
        if (range_reg)
        begin
            rnd = (2*RAW_W+3)'(prod_reg) + (2*RAW_W+3)'(1 << (SCALE_FRAC_BITS - 1));
            shr = rnd >>> SCALE_FRAC_BITS;
        end
        else
        begin
            rnd = (2*RAW_W+3)'(prod_reg) + (2*RAW_W+3)'(1 << (SCALE_FRAC_BITS + 1));
            shr = rnd >>> (SCALE_FRAC_BITS + 2);
        end
        if (shr > (2*RAW_W+3)'((1 << (FIELD_W - 1)) - 1))
            sat_val = FIELD_W'((1 << (FIELD_W - 1)) - 1);
        else if (shr < -(2*RAW_W+3)'(1 << (FIELD_W - 1)))
            sat_val = FIELD_W'(1 << (FIELD_W - 1));
        else
            sat_val = shr[FIELD_W-1:0];
    end

    // CORDIC vectoring step
    logic signed [ROT_W-1:0] xi, yi, dx, dy;
    logic signed [ANG_W-1:0] ang;

    always_comb
    begin
        xi  = ROT_W'(field_reg[0]) <<< 8;
        yi  = ROT_W'(field_reg[1]) <<< 8;
        dx  = y_reg >>> cmd.step;
        dy  = x_reg >>> cmd.step;
        ang = ANG_W'(atan_deg(cmd.step));
    end

    // calibration tracking
    logic [COUNT_W-1:0] seen_plus;
    logic               due;

    always_comb
    begin
        seen_plus = seen_reg + COUNT_W'(1);
        due       = mode_reg && (seen_plus == '0 || seen_plus >= count_reg);
    end

    // divider
    logic [NUM_W-1:0]   num_full;
    logic [HALF_W-1:0]  dhalf;
    logic [QUO_W-1:0]   trial;
    logic               qbit;
    logic [QUO_W-1:0]   quo_next;
    logic [RAW_W*2+2:0] avg_prod;

    always_comb
    begin
        dhalf    = half_reg[cmd.div_axis];
        num_full = {avg_reg, SCALE_FRAC_BITS'(0)};
        trial    = {rem_reg[QUO_W-2:0], num_reg[QUO_W-1]};
        qbit     = (trial >= QUO_W'(dhalf));
        quo_next = {quo_reg[QUO_W-2:0], qbit};
        avg_prod = (RAW_W*2+3)'(hsum_reg) * (RAW_W*2+3)'(RECIP3);
    end

    // heading finish
    logic signed [ANG_W-1:0] zw;
    logic [ANG_W-1:0]        zr;
    logic [ANG_W-10:0]       hraw;
    logic [HEAD_W-1:0]       heading;

    always_comb
    begin
        zw   = (z_reg < 0) ? z_reg + ANG_W'(DEG360_Q16) : z_reg;
        zr   = ANG_W'(zw) + ANG_W'(256);
        hraw = zr[ANG_W-1:9];
        if ((field_reg[0] == '0 && field_reg[1] == '0) ||
            hraw >= (ANG_W-9)'(HEADING_FULL))
            heading = '0;
        else
            heading = hraw[HEAD_W-1:0];
    end

    always_comb
    begin
        sts.in_good   = s_tuser[0] && !s_tuser[1];
        sts.calib_due = due;
        sts.out_free  = !m_tvalid_reg || m_tready;
    end

    // control-like state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_reg    <= 1'b0;
            mode_reg     <= 1'b0;
            count_reg    <= COUNT_W'(CNT_RESET);
            seen_reg     <= '0;
            done_reg     <= 1'b0;
            good_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int a = 0; a < 3; a++)
            begin
                offset_reg[a] <= '0;
                scale_reg[a]  <= SCALE_W'(1 << SCALE_FRAC_BITS);
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_RANGE: range_reg <= cfg_data[0];
                    REG_MODE:
                    begin
                        mode_reg <= cfg_data[0];
                        seen_reg <= '0;
                    end
                    REG_COUNT: count_reg <= cfg_data;
                    default:   ;
                endcase
            end
            if (cmd.load_in)
            begin
                good_reg <= sts.in_good;
                done_reg <= 1'b0;
            end
            if (cmd.track && mode_reg)
            begin
                seen_reg <= due ? '0 : seen_plus;
                done_reg <= due;
            end
            if (cmd.half_calc)
            begin
                for (int a = 0; a < 3; a++)
                    offset_reg[a] <= RAW_W'(((RAW_W+1)'(min_reg[a]) +
                                             (RAW_W+1)'(max_reg[a])) >>> 1);
            end
            if (cmd.div_store)
                scale_reg[cmd.div_axis] <= dsat_reg ? '1 : quo_next;
            if (cmd.out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            raw_reg[0] <= s_tdata[RAW_W-1:0];
            raw_reg[1] <= s_tdata[2*RAW_W-1:RAW_W];
            raw_reg[2] <= s_tdata[3*RAW_W-1:2*RAW_W];
        end
        if (cmd.mul_en)
            prod_reg <= prod;
        if (cmd.sat_en)
            field_reg[cmd.sat_axis] <= sat_val;
        if (cmd.rot_init)
        begin
            if (xi < 0)
            begin
                x_reg <= -xi;
                y_reg <= -yi;
                z_reg <= ANG_W'(DEG180_Q16);
            end
            else
            begin
                x_reg <= xi;
                y_reg <= yi;
                z_reg <= '0;
            end
        end
        if (cmd.rot_step)
        begin
            if (y_reg >= 0)
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + ang;
            end
            else
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - ang;
            end
        end
        if (cmd.track && mode_reg)
        begin
            for (int a = 0; a < 3; a++)
            begin
                if (seen_reg == '0 || raw_reg[a] < min_reg[a])
                    min_reg[a] <= raw_reg[a];
                if (seen_reg == '0 || raw_reg[a] > max_reg[a])
                    max_reg[a] <= raw_reg[a];
            end
        end
        if (cmd.half_calc)
        begin
            for (int a = 0; a < 3; a++)
                half_reg[a] <= HALF_W'(((RAW_W+1)'(max_reg[a]) - (RAW_W+1)'(min_reg[a])) >> 1);
            hsum_reg <= (RAW_W+1)'(((RAW_W+1)'(max_reg[0]) - (RAW_W+1)'(min_reg[0])) >> 1) +
                        (RAW_W+1)'(((RAW_W+1)'(max_reg[1]) - (RAW_W+1)'(min_reg[1])) >> 1) +
                        (RAW_W+1)'(((RAW_W+1)'(max_reg[2]) - (RAW_W+1)'(min_reg[2])) >> 1);
        end
        if (cmd.avg_take)
            avg_reg <= HALF_W'(avg_prod >> RECIP3_SH);
        if (cmd.div_init)
        begin
            // quotient overflows 16 bits (or half-range is zero): saturate
            dsat_reg <= ((HALF_W+QUO_W)'(num_full) >=
                         ((HALF_W+QUO_W)'(dhalf) << QUO_W));
            rem_reg  <= QUO_W'(num_full >> QUO_W);
            num_reg  <= num_full[QUO_W-1:0];
            quo_reg  <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= qbit ? trial - QUO_W'(dhalf) : trial;
            num_reg <= {num_reg[QUO_W-2:0], 1'b0};
            quo_reg <= quo_next;
        end
        if (cmd.out_load)
        begin
            if (good_reg)
            begin
                m_tdata_reg <= OUT_W'({heading, field_reg[2], field_reg[1], field_reg[0]});
                m_tuser_reg <= {done_reg, 1'b1};
            end
            else
            begin
                m_tdata_reg <= '0;
                m_tuser_reg <= 2'b00;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef NO_ASSERTIONS
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load) |-> (!m_tvalid_reg || m_tready))
        else $error("result word overwritten before it was taken");
    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.track && mode_reg && due) |=> (seen_reg == '0 && done_reg))
        else $error("calibration run did not close");
    a_cordic_y: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rot_init |=> (x_reg >= 0))
        else $error("rotation started in left half-plane");
`endif

endmodule

FILE: src/magnetometer_calibrate_heading_core.sv
// A good word passes through the three shared correction multiplies and the
// 16-step CORDIC loop before its result is loaded for output.
// A word that completes a calibration run also runs the three
// 16-bit restoring divisions; a not-ready or overrun word goes straight to output.
// One word in flight; the next is accepted while a result waits on the output.
// rst_n clears config to defaults, offsets to 0 and scales to 1.0.
// ----------------------------------------------------------------------------
// magnetometer_calibrate_heading_core
// Magnetometer correction, heading and min/max calibration, top level.
// ----------------------------------------------------------------------------
module magnetometer_calibrate_heading_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [mch_pkg::IN_W-1:0]    s_tdata,   // raw_x, raw_y, raw_z
    input  logic [1:0]                  s_tuser,   // data_ready, data_overrun
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [mch_pkg::OUT_W-1:0]   m_tdata,   // field_x, field_y, field_z, heading_deg
    output logic [1:0]                  m_tuser,   // sample_valid, calib_done
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [mch_pkg::COUNT_W-1:0] cfg_data
);
    import mch_pkg::*;

    mch_cmd_t cmd;
    mch_sts_t sts;

    assign cfg_ready = 1'b1;

    mch_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mch_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

FILE: bench/tb_magnetometer_calibrate_heading_core.sv
// ----------------------------------------------------------------------------
// tb_magnetometer_calibrate_heading_core
// Streams raw magnetometer words through the core, predicts corrected fields,
// heading and calibration loads, and checks every result word in order.
// ----------------------------------------------------------------------------
module tb_magnetometer_calibrate_heading_core;
    timeunit 1ns;
    timeprecision 1ps;

    import mch_pkg::*;

    typedef struct packed {
        logic              rdy;
        logic              ovr;
        logic signed [15:0] rx;
        logic signed [15:0] ry;
        logic signed [15:0] rz;
    } sample_t;

    typedef struct packed {
        logic               ok;
        logic signed [19:0] fx;
        logic signed [19:0] fy;
        logic signed [19:0] fz;
        logic [15:0]        hdg;
        logic               done;
    } result_t;

    logic                 clk = 0;
    logic                 rst_n = 0;
    logic                 s_tvalid = 0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata = '0;
    logic [1:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 0;
    logic [OUT_W-1:0]     m_tdata;
    logic [1:0]           m_tuser;
    logic                 cfg_valid = 0;
    logic                 cfg_ready;
    logic [1:0]           cfg_index = '0;
    logic [COUNT_W-1:0]   cfg_data = '0;

    magnetometer_calibrate_heading_core dut (.*);

    always #10 clk = ~clk;

    // predictor state
    logic              p_range;
    logic              p_mode;
    logic [11:0]       p_count;
    logic signed [15:0] p_off [3];
    logic [15:0]       p_scale [3];
    logic signed [15:0] p_min [3];
    logic signed [15:0] p_max [3];
    logic [11:0]       p_seen;

    sample_t   pending_words[$];
    result_t   expected_results[$];
    int        errors = 0;
    int        sent = 0;
    longint    cycles = 0;
    bit        calm = 0;
    bit        sink_calm = 0;

    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint corrected_field(longint raw, int a);
        longint c, p, r;
        int sh;
        sh = p_range ? SCALE_FRAC_BITS : SCALE_FRAC_BITS + 2;
        c = raw - longint'(p_off[a]);
        p = c * longint'(p_scale[a]);
        r = fshift(p + (longint'(1) << (sh - 1)), sh);
        if (r > 524287) r = 524287;
        if (r < -524288) r = -524288;
        return r;
    endfunction

    function automatic logic [15:0] heading_of(longint fx, longint fy);
        longint x, y, z, dx, dy, h;
        longint tbl [24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
            58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
            57, 29, 14, 7, 4, 2, 1, 0};
        x = fx * 256;
        y = fy * 256;
        z = 0;
        if (fx == 0 && fy == 0) return 16'd0;
        if (x < 0)
        begin
            x = -x; y = -y; z = DEG180_Q16;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            dx = fshift(y, i);
            dy = fshift(x, i);
            if (y >= 0)
            begin
                x += dx; y -= dy; z += tbl[i];
            end
            else
            begin
                x -= dx; y += dy; z -= tbl[i];
            end
        end
        while (z < 0) z += DEG360_Q16;
        while (z >= DEG360_Q16) z -= DEG360_Q16;
        h = (z + 256) >>> 9;
        return (h >= HEADING_FULL) ? 16'd0 : 16'(h);
    endfunction

    task automatic load_calibration();
        longint half [3];
        longint avg, s;
        for (int a = 0; a < 3; a++)
        begin
            p_off[a] = 16'(fshift(longint'(p_min[a]) + longint'(p_max[a]), 1));
            half[a] = (longint'(p_max[a]) - longint'(p_min[a])) >> 1;
        end
        avg = (half[0] + half[1] + half[2]) / 3;
        for (int a = 0; a < 3; a++)
        begin
            if (half[a] == 0) p_scale[a] = 16'hFFFF;
            else
            begin
                s = (avg << SCALE_FRAC_BITS) / half[a];
                p_scale[a] = (s > 65535) ? 16'hFFFF : 16'(s);
            end
        end
    endtask

    task automatic predict_sample(sample_t w);
        result_t r;
        longint raw [3];
        longint f [3];
        r = '0;
        if (w.rdy && !w.ovr)
        begin
            raw[0] = w.rx; raw[1] = w.ry; raw[2] = w.rz;
            for (int a = 0; a < 3; a++) f[a] = corrected_field(raw[a], a);
            r.ok = 1;
            r.fx = 20'(f[0]); r.fy = 20'(f[1]); r.fz = 20'(f[2]);
            r.hdg = heading_of(f[0], f[1]);
            if (p_mode)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    if (p_seen == 0 || raw[a] < p_min[a]) p_min[a] = 16'(raw[a]);
                    if (p_seen == 0 || raw[a] > p_max[a]) p_max[a] = 16'(raw[a]);
                end
                p_seen = p_seen + 12'd1;
                if (p_seen == 0 || p_seen >= p_count)
                begin
                    load_calibration();
                    p_seen = 0;
                    r.done = 1;
                end
            end
        end
        expected_results.push_back(r);
    endtask

    // driver
    always @(negedge clk)
    begin
        cycles <= cycles + 1;
        if (!s_tvalid && rst_n)
        begin
            if (pending_words.size() > 0 && (calm || $urandom_range(99) >= 16))
            begin
                sample_t w;
                w = pending_words.pop_front();
                predict_sample(w);
                s_tvalid <= 1;
                s_tdata <= {w.rz, w.ry, w.rx};
                s_tuser <= {w.ovr, w.rdy};
                sent <= sent + 1;
            end
            else
                s_tvalid <= 0;
        end
        m_tready <= sink_calm || ($urandom_range(99) >= 16);
    end

    // drop valid once the word is taken
    always @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            s_tvalid <= 0;
    end

    // monitor
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            result_t a, e;
            a.fx = m_tdata[19:0];
            a.fy = m_tdata[39:20];
            a.fz = m_tdata[59:40];
            a.hdg = m_tdata[75:60];
            a.ok = m_tuser[0];
            a.done = m_tuser[1];
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, a);
                errors++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (a !== e)
                begin
                    $display("%0t: mismatch expected ok=%0d fx=%0d fy=%0d fz=%0d hdg=%0d done=%0d",
                        $time, e.ok, e.fx, e.fy, e.fz, e.hdg, e.done);
                    $display("%0t:            actual ok=%0d fx=%0d fy=%0d fz=%0d hdg=%0d done=%0d",
                        $time, a.ok, a.fx, a.fy, a.fz, a.hdg, a.done);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycles > 400000)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(cfg_reg_t idx, int val);
        @(negedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= COUNT_W'(val);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 0;
        case (idx)
            REG_RANGE: p_range = val[0];
            REG_MODE:
            begin
                p_mode = val[0];
                p_seen = 0;
            end
            default: p_count = 12'(val);
        endcase
    endtask

    task automatic drain();
        while (pending_words.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge clk);
        repeat (90) @(posedge clk);
    endtask

    function automatic sample_t rand_word(int good_pct);
        sample_t w;
        w.rx = 16'($urandom);
        w.ry = 16'($urandom);
        w.rz = 16'($urandom);
        if ($urandom_range(3) == 0)
        begin
            w.rx = 16'($signed($urandom_range(400)) - 200);
            w.ry = 16'($signed($urandom_range(400)) - 200);
        end
        if ($urandom_range(99) < good_pct)
        begin
            w.rdy = 1; w.ovr = 0;
        end
        else
        begin
            w.rdy = $urandom_range(1); w.ovr = $urandom_range(1);
        end
        return w;
    endfunction

    task automatic push(logic r, logic o, int x, int y, int z);
        sample_t w;
        w.rdy = r; w.ovr = o;
        w.rx = 16'(x); w.ry = 16'(y); w.rz = 16'(z);
        pending_words.push_back(w);
    endtask

    initial
    begin
        p_range = 0; p_mode = 0; p_count = 12'd500; p_seen = 0;
        for (int a = 0; a < 3; a++)
        begin
            p_off[a] = 0; p_scale[a] = 16'd16384; p_min[a] = 0; p_max[a] = 0;
        end
        repeat (5) @(negedge clk);
        rst_n = 1;

        // directed: extremes, zero vector, skipped words, axis quadrants
        push(1, 0, 0, 0, 0);
        push(1, 0, 32767, 32767, 32767);
        push(1, 0, -32768, -32768, -32768);
        push(0, 0, 123, 456, 789);
        push(1, 1, 123, 456, 789);
        push(0, 1, -1, -1, -1);
        push(1, 0, -100, 0, 5);
        push(1, 0, 100, -1, 5);
        push(1, 0, 0, -100, 5);
        push(1, 0, -100, -1, 5);
        push(1, 0, 32767, -32768, 0);
        drain();
        write_reg(REG_RANGE, 1);
        push(1, 0, 32767, -32768, 1);
        push(1, 0, -3, 7, -32768);
        drain();
        // calibration of two samples with a flat z axis (zero half-range)
        write_reg(REG_COUNT, 2);
        write_reg(REG_MODE, 1);
        push(1, 0, -2000, 1000, 50);
        push(1, 1, 0, 0, 0);
        push(1, 0, 3000, -500, 50);
        push(1, 0, 10, 20, 30);
        drain();
        // count of one, then zero acting as one
        write_reg(REG_COUNT, 1);
        push(1, 0, 1, 2, 3);
        drain();
        write_reg(REG_COUNT, 0);
        push(1, 0, 4, 5, 6);
        drain();

        // random phases across settings, extremes of count included
        for (int ph = 0; ph < 9; ph++)
        begin
            int cnt, n;
            case (ph % 3)
                0: cnt = 1 + $urandom_range(30);
                1: cnt = 4095;
                default: cnt = 1;
            endcase
            write_reg(REG_RANGE, ph % 2);
            write_reg(REG_COUNT, cnt);
            write_reg(REG_MODE, (ph % 4) != 3);
            calm = (ph == 4);
            sink_calm = (ph == 5);
            n = (ph == 1) ? 40 : 160;
            for (int k = 0; k < n; k++)
                pending_words.push_back(rand_word(85));
            drain();
            if (ph == 1)
            begin
                // lowering the count below what was seen completes next word
                write_reg(REG_COUNT, 3);
                pending_words.push_back(rand_word(100));
                drain();
            end
        end
        calm = 0;
        sink_calm = 0;
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
